// ===== hdl/rle_dense_rank_detector_top_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef RLE_DENSE_RANK_DETECTOR_TOP_MACROS_SVH
`define RLE_DENSE_RANK_DETECTOR_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RDR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdr: implication failed");

// A stalled transfer keeps valid and payload on the next edge.
`define RDR_ASSERT_HOLD(lbl, clk, rst, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
    else $error("rdr: stalled transfer changed");

`endif

// ===== hdl/rdr_pkg.sv =====
`timescale 1ns / 1ps

package rdr_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 65536;
  localparam int unsigned DEF_ROW_BITS    = 32;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COL_W     = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned SPARSE_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_N_ROWS          = 2'd0,
    REG_DENSE_THRESHOLD = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] n_rows;
    logic [DATA_W-1:0] dense_threshold;
  } rdr_cfg_t;

  // One finished column or one rejected entry, between the two stages.
  typedef struct packed {
    logic              reject;
    logic [COL_W-1:0]  column;
    logic [DATA_W-1:0] best_rank;
    logic [DATA_W-1:0] best_run;
  } col_rec_t;

endpackage

// ===== hdl/rdr_if.sv =====
`timescale 1ns / 1ps

interface rdr_entry_if;
  import rdr_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rank;
  logic [DATA_W-1:0] run_length;
  modport source(output valid, rank, run_length, input ready);
  modport sink(input valid, rank, run_length, output ready);
endinterface

interface rdr_cfg_if;
  import rdr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface rdr_result_if;
  import rdr_pkg::*;
  logic                valid;
  logic                ready;
  logic                status;
  logic [COL_W-1:0]    column_index;
  logic                is_dense;
  logic [DATA_W-1:0]   dense_rank_value;
  logic [DATA_W-1:0]   longest_run;
  logic [DATA_W-1:0]   explicit_rows;
  logic [ACC_W-1:0]    store_offset;
  logic [COL_W-1:0]    dense_slot;
  logic [ACC_W-1:0]    total_explicit;
  logic [SPARSE_W-1:0] sparse_columns;
  modport source(output valid, status, column_index, is_dense, dense_rank_value,
                 longest_run, explicit_rows, store_offset, dense_slot,
                 total_explicit, sparse_columns, input ready);
  modport sink(input valid, status, column_index, is_dense, dense_rank_value,
               longest_run, explicit_rows, store_offset, dense_slot,
               total_explicit, sparse_columns, output ready);
endinterface

// ===== hdl/rdr_run_tracker.sv =====
`timescale 1ns / 1ps

module rdr_run_tracker #(
  parameter int unsigned MAX_COLUMNS = rdr_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned ROW_BITS    = rdr_pkg::DEF_ROW_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  rdr_pkg::rdr_cfg_t cfg,
  rdr_entry_if.sink        entry,
  output logic             rec_valid,
  output rdr_pkg::col_rec_t rec,
  input  logic             rec_ready
);
  import rdr_pkg::*;

  localparam int unsigned MC_W  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CMP_W = (COL_W + 1 > MC_W) ? COL_W + 1 : MC_W;

  // input register
  logic                a_valid;
  logic [DATA_W-1:0]   a_rank;
  logic [ROW_BITS-1:0] a_len;

  // column state
  logic [ROW_BITS-1:0] rows_so_far;
  logic [ROW_BITS-1:0] merged_run;
  logic [DATA_W-1:0]   previous_rank;
  logic                previous_valid;
  logic [ROW_BITS-1:0] best_run;
  logic [DATA_W-1:0]   best_rank;
  logic [COL_W-1:0]    column_count;

  logic                rec_space;
  logic                a_fire;
  logic [ROW_BITS-1:0] rows;
  logic [ROW_BITS:0]   total;
  logic                over;
  logic                done;
  logic                emit;
  logic [ROW_BITS-1:0] merged_run_next;
  logic                better;
  logic [ROW_BITS-1:0] best_run_next;
  logic [DATA_W-1:0]   best_rank_next;
  logic [CMP_W-1:0]    col_wide;
  logic [COL_W-1:0]    column_count_next;
  col_rec_t            rec_next;

  assign rec_space   = !rec_valid || rec_ready;
  assign a_fire      = a_valid && rec_space;
  assign entry.ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (entry.ready) begin
      a_valid <= entry.valid;
    end
    if (entry.valid && entry.ready) begin
      a_rank <= entry.rank;
      a_len  <= entry.run_length[ROW_BITS-1:0];
    end
  end

  always_comb begin
    rows            = cfg.n_rows[ROW_BITS-1:0];
    total           = {1'b0, rows_so_far} + {1'b0, a_len};
    over            = total > {1'b0, rows};
    done            = !over && (total[ROW_BITS-1:0] == rows);
    emit            = over || done;
    merged_run_next = (previous_valid && (a_rank == previous_rank)) ?
                      merged_run + a_len : a_len;
    better          = merged_run_next > best_run;
    best_run_next   = better ? merged_run_next : best_run;
    best_rank_next  = better ? a_rank : best_rank;
    col_wide        = CMP_W'(column_count) + CMP_W'(1);
    column_count_next = (col_wide >= CMP_W'(MAX_COLUMNS)) ? '0 : col_wide[COL_W-1:0];
    rec_next.reject = over;
    rec_next.column = column_count;
    rec_next.best_rank = over ? '0 : best_rank_next;
    rec_next.best_run  = over ? '0 : DATA_W'(best_run_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_so_far    <= '0;
      merged_run     <= '0;
      previous_rank  <= '0;
      previous_valid <= 1'b0;
      best_run       <= '0;
      best_rank      <= '0;
      column_count   <= '0;
    end else if (a_fire && !over) begin
      if (done) begin
        rows_so_far    <= '0;
        merged_run     <= '0;
        previous_rank  <= '0;
        previous_valid <= 1'b0;
        best_run       <= '0;
        best_rank      <= '0;
        column_count   <= column_count_next;
      end else begin
        rows_so_far    <= total[ROW_BITS-1:0];
        merged_run     <= merged_run_next;
        previous_rank  <= a_rank;
        previous_valid <= 1'b1;
        best_run       <= best_run_next;
        best_rank      <= best_rank_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rec_space) begin
      rec_valid <= a_fire && emit;
    end
    if (a_fire && emit) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== hdl/rdr_column_alloc.sv =====
`timescale 1ns / 1ps

module rdr_column_alloc #(
  parameter int unsigned ROW_BITS = rdr_pkg::DEF_ROW_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  rdr_pkg::rdr_cfg_t cfg,
  input  logic              rec_valid,
  input  rdr_pkg::col_rec_t rec,
  output logic              rec_ready,
  rdr_result_if.source      result
);
  import rdr_pkg::*;

  logic [SPARSE_W-1:0] sparse_count;
  logic [COL_W-1:0]    dense_count;
  logic [ACC_W-1:0]    compact_accum;
  logic [ACC_W-1:0]    explicit_accum;

  logic                b_fire;
  logic [DATA_W-1:0]   rows;
  logic                dense;
  logic [DATA_W-1:0]   expl;
  logic [SPARSE_W-1:0] sparse_count_next;
  logic [ACC_W-1:0]    explicit_accum_next;

  assign rec_ready = !result.valid || result.ready;
  assign b_fire    = rec_valid && rec_ready;

  always_comb begin
    rows  = DATA_W'(cfg.n_rows[ROW_BITS-1:0]);
    dense = rec.best_run > cfg.dense_threshold;
    expl  = dense ? rows - rec.best_run : rows;
    sparse_count_next   = dense ? sparse_count : sparse_count + SPARSE_W'(1);
    explicit_accum_next = explicit_accum + ACC_W'(expl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sparse_count   <= '0;
      dense_count    <= '0;
      compact_accum  <= '0;
      explicit_accum <= '0;
    end else if (b_fire && !rec.reject) begin
      sparse_count   <= sparse_count_next;
      explicit_accum <= explicit_accum_next;
      if (dense) begin
        dense_count   <= dense_count + COL_W'(1);
        compact_accum <= compact_accum + ACC_W'(expl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rec_ready) begin
      result.valid <= rec_valid;
    end
    if (b_fire) begin
      result.column_index <= rec.column;
      if (rec.reject) begin
        result.status           <= 1'b1;
        result.is_dense         <= 1'b0;
        result.dense_rank_value <= '0;
        result.longest_run      <= '0;
        result.explicit_rows    <= '0;
        result.store_offset     <= '0;
        result.dense_slot       <= '0;
        result.total_explicit   <= '0;
        result.sparse_columns   <= '0;
      end else begin
        result.status           <= 1'b0;
        result.is_dense         <= dense;
        result.dense_rank_value <= rec.best_rank;
        result.longest_run      <= rec.best_run;
        result.explicit_rows    <= expl;
        result.store_offset     <= dense ? compact_accum : ACC_W'(sparse_count);
        result.dense_slot       <= dense ? dense_count : '0;
        result.total_explicit   <= explicit_accum_next;
        result.sparse_columns   <= sparse_count_next;
      end
    end
  end

endmodule

// ===== hdl/rle_dense_rank_detector_top.sv =====
`timescale 1ns / 1ps

// Dense-rank detector: accepts one run-length entry (rank, run_length) per clock while
// the output is not stalled, and merges equal-rank neighbours into runs, tracking the
// longest run of each column of n_rows rows. A finished column, or an entry that would
// overshoot n_rows, yields one result after passing the input register, the record
// register and the result register; all other entries yield none. The column state is
// updated in the run tracker; the dense/sparse allocation and running sums follow in a
// second stage and the result register holds each result until it is taken. Register
// writes are registered and are expected only while no entry is in flight.

module rle_dense_rank_detector_top #(
  parameter int unsigned MAX_COLUMNS = rdr_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned ROW_BITS    = rdr_pkg::DEF_ROW_BITS
) (
  input  logic         clk,
  input  logic         rst,
  rdr_entry_if.sink    entry,
  rdr_cfg_if.sink      cfg,
  rdr_result_if.source result
);
  import rdr_pkg::*;

  rdr_cfg_t cfg_regs;
  logic     rec_valid;
  logic     rec_ready;
  col_rec_t rec;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.n_rows          <= DATA_W'(1);
      cfg_regs.dense_threshold <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_N_ROWS:          cfg_regs.n_rows          <= cfg.data;
        REG_DENSE_THRESHOLD: cfg_regs.dense_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  rdr_run_tracker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .ROW_BITS   (ROW_BITS)
  ) u_run_tracker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .entry    (entry),
    .rec_valid(rec_valid),
    .rec      (rec),
    .rec_ready(rec_ready)
  );

  rdr_column_alloc #(
    .ROW_BITS(ROW_BITS)
  ) u_column_alloc (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .rec_valid(rec_valid),
    .rec      (rec),
    .rec_ready(rec_ready),
    .result   (result)
  );

endmodule

// ===== hdl/rdr_checker.sv =====
`timescale 1ns / 1ps
`include "rle_dense_rank_detector_top_macros.svh"

module rdr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         status,
  input logic                         is_dense,
  input logic [rdr_pkg::DATA_W-1:0]   longest_run,
  input logic [rdr_pkg::DATA_W-1:0]   explicit_rows,
  input logic [rdr_pkg::ACC_W-1:0]    store_offset,
  input logic [rdr_pkg::COL_W-1:0]    dense_slot,
  input logic [rdr_pkg::ACC_W-1:0]    total_explicit,
  input logic [rdr_pkg::SPARSE_W-1:0] sparse_columns
);
  import rdr_pkg::*;

  logic [ACC_W+DATA_W-1:0] held;
  logic                    sparse_ok;

  assign held      = {store_offset, longest_run};
  assign sparse_ok = (SPARSE_W'(store_offset) + SPARSE_W'(1) == sparse_columns) &&
                     (store_offset[ACC_W-1:SPARSE_W] == '0);

  `RDR_ASSERT_HOLD(a_result_hold, clk, rst, res_valid, res_ready, held)
  `RDR_ASSERT_IMP(a_reject_clean, clk, rst, res_valid && status, !is_dense && longest_run == '0 && explicit_rows == '0 && total_explicit == '0)
  `RDR_ASSERT_IMP(a_sparse_slot, clk, rst, res_valid && !status && !is_dense, dense_slot == '0 && sparse_ok)
  `RDR_ASSERT_IMP(a_dense_run, clk, rst, res_valid && !status && is_dense, longest_run != '0)

endmodule

bind rle_dense_rank_detector_top rdr_checker u_rdr_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .status        (result.status),
  .is_dense      (result.is_dense),
  .longest_run   (result.longest_run),
  .explicit_rows (result.explicit_rows),
  .store_offset  (result.store_offset),
  .dense_slot    (result.dense_slot),
  .total_explicit(result.total_explicit),
  .sparse_columns(result.sparse_columns)
);
